[rtl/hmed_pkg.sv]
// Package for the HTTP message end detector.
// Holds the shared types, the header name and blank line tables and defaults.
// No dependencies.
`default_nettype none

package hmed_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int NAME_LEN  = 15;
    localparam int BLANK_LEN = 4;
    localparam int LEN_BITS  = 32;

    typedef enum logic [1:0] {
        REASON_NONE    = 2'd0,
        REASON_HEADERS = 2'd1,
        REASON_BODY    = 2'd2,
        REASON_CLOSED  = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_SPACE  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic       closed;
        logic [7:0] data;
    } t_step;

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] blank_char(input logic [1:0] idx);
        return idx[0] ? 8'h0A : 8'h0D;
    endfunction

endpackage

`default_nettype wire

[rtl/hmed_len_parser.sv]
// Content-Length header name matcher and decimal value parser.
// Depends on hmed_pkg.
`default_nettype none

module hmed_len_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hmed_pkg::t_step i_step,
    input  wire logic           i_headers_done,
    input  wire logic           i_clear,
    output logic [31:0]         o_len,
    output logic [31:0]         o_len_next
);
    import hmed_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_len, n_len;
    logic        w_en;
    logic        w_is_digit;
    logic [35:0] w_sum;
    logic [3:0]  w_match_idx;

    assign w_en       = i_step.valid && !i_step.closed && !i_headers_done;
    assign w_is_digit = (i_step.data >= "0") && (i_step.data <= "9");
    assign w_sum      = 36'({r_len, 3'b000}) + 36'({r_len, 1'b0})
                      + 36'(i_step.data[3:0]);

    always_comb begin
        if ((r_idx < 4'(NAME_LEN)) && (i_step.data == name_char(r_idx))) begin
            w_match_idx = r_idx + 4'd1;
        end else begin
            w_match_idx = (i_step.data == name_char(4'd0)) ? 4'd1 : 4'd0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (w_en) begin
            unique case (r_phase)
                PH_NAME: begin
                    n_idx = w_match_idx;
                    if (w_match_idx >= 4'(NAME_LEN)) begin
                        n_phase = PH_SPACE;
                    end
                end
                PH_SPACE: begin
                    if (w_is_digit || i_step.data == "+") begin
                        n_phase = PH_DIGITS;
                    end else if (i_step.data != " ") begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (!w_is_digit) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_len = r_len;
        if (w_en && (r_phase == PH_SPACE || r_phase == PH_DIGITS)) begin
            if (w_is_digit) begin
                n_len = (w_sum[35:32] != 4'd0) ? '1 : w_sum[31:0];
            end else if (r_phase == PH_SPACE && i_step.data == "-") begin
                n_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_NAME;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
        end
    end

    assign o_len      = r_len;
    assign o_len_next = n_len;

endmodule

`default_nettype wire

[rtl/hmed_frame_tracker.sv]
// Byte counter, blank line detector and request completion logic.
// Depends on hmed_pkg.
`default_nettype none

module hmed_frame_tracker #(
    parameter int COUNT_BITS = hmed_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hmed_pkg::t_step i_step,
    input  wire logic [31:0]     i_len,
    output logic                 o_headers_done,
    output hmed_pkg::t_reason    o_reason,
    output logic [31:0]          o_total,
    output logic [31:0]          o_body_offset
);
    import hmed_pkg::*;

    localparam int LimW = (COUNT_BITS < LEN_BITS) ? COUNT_BITS : LEN_BITS;
    localparam int TgtW = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CountLimit = COUNT_BITS'({LimW{1'b1}});

    logic [2:0]            r_prog, n_prog;
    logic                  r_hc, n_hc;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_bs, n_bs;
    logic [TgtW-1:0]       r_target, n_target;
    t_reason               w_reason;
    logic                  w_byte;

    assign w_byte = i_step.valid && !i_step.closed;

    always_comb begin
        n_prog   = r_prog;
        n_hc     = r_hc;
        n_count  = r_count;
        n_bs     = r_bs;
        n_target = r_target;
        w_reason = REASON_NONE;
        if (i_step.valid && i_step.closed) begin
            w_reason = REASON_CLOSED;
        end else if (w_byte) begin
            if (r_count < CountLimit) begin
                n_count = r_count + COUNT_BITS'(1);
            end
            if (!r_hc) begin
                if (r_prog < 3'(BLANK_LEN) && i_step.data == blank_char(r_prog[1:0])) begin
                    n_prog = r_prog + 3'd1;
                end else begin
                    n_prog = (i_step.data == blank_char(2'd0)) ? 3'd1 : 3'd0;
                end
                if (n_prog >= 3'(BLANK_LEN)) begin
                    n_hc     = 1'b1;
                    n_bs     = n_count;
                    n_target = TgtW'(n_count) + TgtW'(i_len);
                    if (i_len == '0) begin
                        w_reason = REASON_HEADERS;
                    end
                end
            end else if (i_len != '0 && TgtW'(n_count) == r_target) begin
                w_reason = REASON_BODY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_reason != REASON_NONE) begin
            r_prog   <= '0;
            r_hc     <= 1'b0;
            r_count  <= '0;
            r_bs     <= '0;
            r_target <= '0;
        end else begin
            r_prog   <= n_prog;
            r_hc     <= n_hc;
            r_count  <= n_count;
            r_bs     <= n_bs;
            r_target <= n_target;
        end
    end

    assign o_headers_done = r_hc;
    assign o_reason       = w_reason;
    assign o_total        = 32'(n_count);
    assign o_body_offset  = n_hc ? 32'(n_bs) : 32'd0;

endmodule

`default_nettype wire

[rtl/http_message_end_detector.sv]
// HTTP message end detector, top level.
// Depends on hmed_pkg, hmed_len_parser and hmed_frame_tracker.
//
// The slave channel carries one transaction per received request byte in
// s_axis_tdata, or a peer-closed event when s_axis_tuser is high. The master
// channel returns exactly one result transaction for every input transaction.
// The result tlast marks the transaction that completes a request and tuser
// gives the reason: headers only, last body byte, or closed by the peer.
// After a completing transaction all counters restart for the next request.
//
// A result appears on the master side in the cycle after its input is
// accepted. Throughput is one transaction per cycle while the receiver
// does not stall, limited by the single pass through the match,
// multiply-by-ten and length compare logic into the result register.
// A synchronous active-low reset clears all parser and tracker state and empties
// the result register. When the receiver stalls, the result register holds its
// value and s_axis_tready stays high only while that result is being taken.
`default_nettype none

module http_message_end_detector #(
    parameter int COUNT_BITS = hmed_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] peer_closed
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [31:0] total_length, [63:32] body_offset,
                                             // [95:64] announced_length
    output logic             m_axis_tlast,   // request_done
    output logic [1:0]       m_axis_tuser    // [1:0] done_reason
);
    import hmed_pkg::*;

    t_step       w_step;
    logic        w_accept;
    logic        w_hc;
    logic [31:0] w_len;
    logic [31:0] w_len_next;
    logic [31:0] w_total;
    logic [31:0] w_body_offset;
    t_reason     w_reason;

    logic        r_valid;
    logic [95:0] r_tdata;
    t_reason     r_reason;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_step        = '{valid: w_accept, closed: s_axis_tuser, data: s_axis_tdata};

    hmed_len_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_headers_done (w_hc),
        .i_clear        (w_reason != REASON_NONE),
        .o_len          (w_len),
        .o_len_next     (w_len_next)
    );

    hmed_frame_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_len          (w_len),
        .o_headers_done (w_hc),
        .o_reason       (w_reason),
        .o_total        (w_total),
        .o_body_offset  (w_body_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tdata  <= {w_len_next, w_body_offset, w_total};
            r_reason <= w_reason;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = (r_reason != REASON_NONE);
    assign m_axis_tuser  = r_reason;

    a_body_not_past_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] <= m_axis_tdata[31:0]))
        else $error("body offset exceeds total length");

    a_headers_end_here: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == REASON_HEADERS) |->
        (m_axis_tdata[63:32] == m_axis_tdata[31:0] && m_axis_tdata[95:64] == 32'd0))
        else $error("headers-only completion with inconsistent totals");

    a_body_end_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == REASON_BODY) |->
        (33'(m_axis_tdata[31:0]) == 33'(m_axis_tdata[63:32]) + 33'(m_axis_tdata[95:64])))
        else $error("body completion not at the announced length");

    a_restart_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_reason != REASON_NONE) |=> (w_hc == 1'b0 && w_len == 32'd0))
        else $error("state not cleared after request completion");

endmodule

`default_nettype wire
